// ===== sv/jebr_pkg.sv =====
// Package for the JPEG entropy-coded segment bit reader.
// Holds the channel payload types, operation and status codes and shared constants.
// No dependencies.
package jebr_pkg;

   // Request codes as they arrive on the request channel
   localparam logic [2:0] REQ_PUSH    = 3'd0;
   localparam logic [2:0] REQ_GET     = 3'd1;
   localparam logic [2:0] REQ_PEEK    = 3'd2;
   localparam logic [2:0] REQ_SKIP    = 3'd3;
   localparam logic [2:0] REQ_RESTART = 3'd4;

   // Classified operation codes carried through the queue
   localparam logic [2:0] OP_PUSH    = 3'd0;
   localparam logic [2:0] OP_GET     = 3'd1;
   localparam logic [2:0] OP_PEEK    = 3'd2;
   localparam logic [2:0] OP_SKIP    = 3'd3;
   localparam logic [2:0] OP_RESTART = 3'd4;
   localparam logic [2:0] OP_NOP     = 3'd5;

   // Response status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_SHORT   = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_IGNORED = 2'd3;

   localparam logic [7:0]  STUFF_BYTE   = 8'hFF;
   localparam logic [4:0]  MAX_REQ_BITS = 5'd24;
   localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [2:0] req_type;
      logic [7:0] data_byte;
      logic [4:0] bit_count;
   } req_payload_type;

   typedef struct packed {
      logic [23:0] bits_value;
      logic [1:0]  status;
      logic        marker_found;
      logic [7:0]  marker_value;
      logic [15:0] zeros_inserted;
      logic [5:0]  bits_available;
   } rsp_payload_type;

   // Classified operation held in the queue
   typedef struct packed {
      logic [2:0] op;
      logic [7:0] data_byte;
      logic [4:0] count;
      logic       byte_is_ff;
      logic       byte_is_zero;
   } op_entry_type;

   // Queue control driven by the front into the queue
   typedef struct packed {
      logic full;
      logic push;
   } queue_ctrl_type;

endpackage

// ===== sv/jebr_front.sv =====
// Front end: accepts request transactions and classifies them into queue entries.
// Depends on jebr_pkg.
module jebr_front
   import jebr_pkg::*;
(
   input  logic            req_valid,
   input  req_payload_type req_data,
   input  logic            queue_full,
   output logic            req_stall,
   output queue_ctrl_type  queue_ctrl,
   output op_entry_type    entry
);

   // Stall while the queue has no free slot
   assign req_stall       = queue_full;
   assign queue_ctrl.full = queue_full;
   assign queue_ctrl.push = req_valid && !queue_full;

   // Decode request type, clamp count, pre-compare the byte
   always_comb begin
      entry.data_byte    = req_data.data_byte;
      entry.byte_is_ff   = (req_data.data_byte == STUFF_BYTE);
      entry.byte_is_zero = (req_data.data_byte == 8'h00);
      entry.count        = (req_data.bit_count > MAX_REQ_BITS) ? MAX_REQ_BITS
                                                               : req_data.bit_count;
      case (req_data.req_type)
         REQ_PUSH:    entry.op = OP_PUSH;
         REQ_GET:     entry.op = OP_GET;
         REQ_PEEK:    entry.op = OP_PEEK;
         REQ_SKIP:    entry.op = OP_SKIP;
         REQ_RESTART: entry.op = OP_RESTART;
         default:     entry.op = OP_NOP;
      endcase
   end

endmodule

// ===== sv/jebr_queue.sv =====
// Short flop-based queue decoupling the front end from the execution back end.
// Depends on jebr_pkg.
module jebr_queue
   import jebr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  queue_ctrl_type queue_ctrl,
   input  op_entry_type   wr_entry,
   output logic           full,
   output logic           rd_valid,
   output op_entry_type   rd_entry,
   input  logic           rd_pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   op_entry_type     slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign rd_valid = (count_ff != '0);
   assign rd_entry = slot_ff[rd_ptr_ff];
   assign do_push  = queue_ctrl.push;
   assign do_pop   = rd_pop && rd_valid;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

// ===== sv/jebr_back.sv =====
// Back end: executes queued operations on the bit reservoir and registers responses.
// Depends on jebr_pkg.
module jebr_back
   import jebr_pkg::*;
#(
   parameter int RESERVOIR_BITS = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_valid,
   input  op_entry_type    q_entry,
   output logic            q_pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   localparam int HW = $clog2(RESERVOIR_BITS + 1);
   localparam logic [HW-1:0] ROOM_LIMIT = HW'(RESERVOIR_BITS - 8);

   logic [RESERVOIR_BITS-1:0] res_ff, res_in;
   logic [HW-1:0]             held_ff, held_in;
   logic                      ff_pend_ff, ff_pend_in;
   logic                      marker_ff, marker_in;
   logic [7:0]                marker_byte_ff, marker_byte_in;
   logic [15:0]               zero_cnt_ff, zero_cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_payload_type           rsp_data_ff, rsp_data_in;

   logic                      out_free;
   logic                      room;
   logic [7:0]                app_byte;
   logic [RESERVOIR_BITS-1:0] res_app;
   logic [HW-1:0]             need;
   logic                      short_held;
   logic [4:0]                deficit;
   logic [4:0]                deficit_up;
   logic [1:0]                fill_bytes;
   logic [RESERVOIR_BITS-1:0] res_fill;
   logic [HW-1:0]             held_fill;
   logic [HW-1:0]             shift_amt;
   logic [RESERVOIR_BITS-1:0] res_shifted;
   logic [23:0]               extract;
   logic [16:0]               zero_sum;
   logic [15:0]               zero_sat;
   logic [23:0]               value;
   logic [1:0]                status;

   // Pop whenever the output register is free or being drained
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign q_pop     = q_valid && out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Push path: byte append
   assign room     = (held_ff <= ROOM_LIMIT);
   assign app_byte = ff_pend_ff ? STUFF_BYTE : q_entry.data_byte;
   assign res_app  = {res_ff[RESERVOIR_BITS-9:0], app_byte};

   // Read path: whole zero bytes appended after a marker until enough bits are held
   assign need       = HW'(q_entry.count);
   assign short_held = (held_ff < need);
   assign deficit    = 5'(need - held_ff);
   assign deficit_up = deficit + 5'd7;
   assign fill_bytes = (short_held && marker_ff) ? deficit_up[4:3] : 2'd0;
   assign held_fill  = held_ff + HW'({fill_bytes, 3'b000});

   always_comb begin
      case (fill_bytes)
         2'd0:    res_fill = res_ff;
         2'd1:    res_fill = res_ff << 8;
         2'd2:    res_fill = res_ff << 16;
         2'd3:    res_fill = res_ff << 24;
         default: res_fill = res_ff;
      endcase
   end

   // MSB-first extraction of the requested bits
   assign shift_amt   = held_fill - need;
   assign res_shifted = res_fill >> shift_amt;
   assign extract     = res_shifted[23:0] & ~(24'hFF_FFFF << q_entry.count);

   // Saturating count of inserted zero bytes
   assign zero_sum = {1'b0, zero_cnt_ff} + 17'(fill_bytes);
   assign zero_sat = zero_sum[16] ? COUNT_MAX : zero_sum[15:0];

   // Operation execution
   always_comb begin
      res_in         = res_ff;
      held_in        = held_ff;
      ff_pend_in     = ff_pend_ff;
      marker_in      = marker_ff;
      marker_byte_in = marker_byte_ff;
      zero_cnt_in    = zero_cnt_ff;
      value          = '0;
      status         = ST_OK;
      case (q_entry.op)
         OP_PUSH: begin
            if (marker_ff) begin
               status = ST_IGNORED;
            end else if (ff_pend_ff && !q_entry.byte_is_zero) begin
               ff_pend_in     = 1'b0;
               marker_in      = 1'b1;
               marker_byte_in = q_entry.data_byte;
            end else if (!ff_pend_ff && q_entry.byte_is_ff) begin
               ff_pend_in = 1'b1;
            end else if (!room) begin
               status = ST_FULL;
            end else begin
               res_in     = res_app;
               held_in    = held_ff + HW'(8);
               ff_pend_in = 1'b0;
            end
         end
         OP_GET, OP_PEEK, OP_SKIP: begin
            if (q_entry.count != 5'd0) begin
               if (short_held && !marker_ff) begin
                  status = ST_SHORT;
               end else begin
                  res_in      = res_fill;
                  zero_cnt_in = zero_sat;
                  if (q_entry.op != OP_SKIP) begin
                     value = extract;
                  end
                  if (q_entry.op == OP_PEEK) begin
                     held_in = held_fill;
                  end else begin
                     held_in = held_fill - need;
                  end
               end
            end
         end
         OP_RESTART: begin
            res_in         = '0;
            held_in        = '0;
            ff_pend_in     = 1'b0;
            marker_in      = 1'b0;
            marker_byte_in = '0;
            zero_cnt_in    = '0;
         end
         default: begin
         end
      endcase
   end

   // Response assembly
   always_comb begin
      rsp_data_in.bits_value     = value;
      rsp_data_in.status         = status;
      rsp_data_in.marker_found   = marker_in;
      rsp_data_in.marker_value   = marker_byte_in;
      rsp_data_in.zeros_inserted = zero_cnt_in;
      rsp_data_in.bits_available = held_in[5:0];
      if (q_pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Reader state, updated once per executed operation
   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff         <= '0;
         held_ff        <= '0;
         ff_pend_ff     <= 1'b0;
         marker_ff      <= 1'b0;
         marker_byte_ff <= '0;
         zero_cnt_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            res_ff         <= res_in;
            held_ff        <= held_in;
            ff_pend_ff     <= ff_pend_in;
            marker_ff      <= marker_in;
            marker_byte_ff <= marker_byte_in;
            zero_cnt_ff    <= zero_cnt_in;
         end
      end
   end

   // Response payload register
   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== sv/jpeg_entropy_bit_reader.sv =====
// JPEG entropy-coded segment bit reader: top level joining front end, queue and back end.
// Depends on jebr_pkg, jebr_front, jebr_queue and jebr_back.
//
// Usage:
//   Request channel (req_valid / req_stall / req_data) carries push-byte, get, peek,
//   skip and restart requests; a transaction completes when req_valid is high and
//   req_stall is low. Pushed bytes are unstuffed (0xFF 0x00 gives one 0xFF); a 0xFF
//   followed by a nonzero byte records a marker, after which reads are padded with
//   zero bytes. Each request gives exactly one response on the rsp_ channel, with
//   the requested bits, a status and the reader state after the request.
//   A request accepted on the request channel passes through the queue and is executed
//   into the response register. Throughput: one request per cycle while the receiver
//   does not stall, set by the back-end execute step and the response register after it.
//   When the receiver stalls, the response register holds and up to two requests
//   wait in the queue; req_stall rises once the queue is full.
//   Reset (synchronous, active high) empties the queue and clears the reservoir,
//   the marker and the zero count. No initialisation pass is needed.
module jpeg_entropy_bit_reader
   import jebr_pkg::*;
#(
   parameter int RESERVOIR_BITS = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   queue_ctrl_type queue_ctrl;
   op_entry_type   wr_entry;
   op_entry_type   rd_entry;
   logic           queue_full;
   logic           q_valid;
   logic           q_pop;

   jebr_front u_front (
      .req_valid  (req_valid),
      .req_data   (req_data),
      .queue_full (queue_full),
      .req_stall  (req_stall),
      .queue_ctrl (queue_ctrl),
      .entry      (wr_entry)
   );

   jebr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .queue_ctrl (queue_ctrl),
      .wr_entry   (wr_entry),
      .full       (queue_full),
      .rd_valid   (q_valid),
      .rd_entry   (rd_entry),
      .rd_pop     (q_pop)
   );

   jebr_back #(
      .RESERVOIR_BITS (RESERVOIR_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_entry   (rd_entry),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sv/jebr_checker.sv =====
// Port-level checker for the bit reader, attached to the top level by a bind.
// Depends on jebr_pkg and jpeg_entropy_bit_reader.
module jebr_checker
   import jebr_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_data
);

   // A stalled response transaction stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // A refused short read returns nothing and implies no marker
   a_short_no_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_SHORT |->
         rsp_data.bits_value == 24'd0 && !rsp_data.marker_found)
      else $error("short status with marker or data");

   // Bytes are only ignored once a marker is recorded
   a_ignored_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_IGNORED |-> rsp_data.marker_found)
      else $error("byte ignored without marker");

   // Zero padding only happens after a marker
   a_zeros_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zeros_inserted != 16'd0 |-> rsp_data.marker_found)
      else $error("zero bytes counted without marker");

endmodule

bind jpeg_entropy_bit_reader jebr_checker u_jebr_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== dv/tb_jpeg_entropy_bit_reader.sv =====
// Self-checking testbench for jpeg_entropy_bit_reader: a directed table, then random segments.
// Keeps its own bit-level predictor of the unstuffing reader and checks every response.
// Depends on jebr_pkg and the jpeg_entropy_bit_reader RTL.
module tb_jpeg_entropy_bit_reader;
   timeunit 1ns;
   timeprecision 1ps;
   import jebr_pkg::*;

   localparam int RESERVOIR_BITS = 32;
   // request codes the block treats as no-ops
   localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
   localparam logic [2:0] REQ_UNUSED_HI = 3'd7;
   localparam int HOLD_CYCLES = 150;
   localparam int MAX_PRINTS  = 200;

   typedef struct {
      req_payload_type req;
      bit              fixed;
      rsp_payload_type want;
   } stim_row_type;

   logic            clock     = 1'b0;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_requests = 0;
   int holds_started = 0;
   int hold_left     = 0;
   int mismatches    = 0;

   stim_row_type    offered[$];
   rsp_payload_type expected_rsp[$];

   // predicted reader state
   logic [63:0] held_bits;
   int unsigned held_count;
   bit          stuff_pending;
   bit          marker_seen_r;
   logic [7:0]  marker_code;
   logic [15:0] zero_fills;

   jpeg_entropy_bit_reader #(.RESERVOIR_BITS(RESERVOIR_BITS)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor
   function automatic void clear_reader();
      held_bits     = '0;
      held_count    = 0;
      stuff_pending = 1'b0;
      marker_seen_r = 1'b0;
      marker_code   = '0;
      zero_fills    = '0;
   endfunction

   function automatic void append_byte(logic [7:0] b);
      held_bits  = ((held_bits << 8) | 64'(b)) & ((64'd1 << RESERVOIR_BITS) - 64'd1);
      held_count += 8;
   endfunction

   function automatic logic [1:0] push_byte(logic [7:0] b);
      if (marker_seen_r)
         return ST_IGNORED;
      if (stuff_pending) begin
         // second half of a pair: 0x00 unstuffs, anything else is a marker
         if (b == 8'h00) begin
            if (held_count + 8 > RESERVOIR_BITS)
               return ST_FULL;
            append_byte(STUFF_BYTE);
            stuff_pending = 1'b0;
            return ST_OK;
         end
         stuff_pending = 1'b0;
         marker_seen_r = 1'b1;
         marker_code   = b;
         return ST_OK;
      end
      if (b == STUFF_BYTE) begin
         stuff_pending = 1'b1;
         return ST_OK;
      end
      if (held_count + 8 > RESERVOIR_BITS)
         return ST_FULL;
      append_byte(b);
      return ST_OK;
   endfunction

   function automatic rsp_payload_type reader_response(req_payload_type rq);
      rsp_payload_type r;
      int unsigned     n;
      logic [63:0]     field;
      r = '0;
      case (rq.req_type)
         REQ_PUSH: r.status = push_byte(rq.data_byte);
         REQ_GET, REQ_PEEK, REQ_SKIP: begin
            n = 32'((rq.bit_count > MAX_REQ_BITS) ? MAX_REQ_BITS : rq.bit_count);
            if (n != 0 && held_count < n && !marker_seen_r) begin
               r.status = ST_SHORT;
            end else if (n != 0) begin
               // past a marker, pad with whole zero bytes
               while (held_count < n) begin
                  append_byte(8'h00);
                  if (zero_fills != COUNT_MAX)
                     zero_fills++;
               end
               field = (held_bits >> (held_count - n)) & ((64'd1 << n) - 64'd1);
               if (rq.req_type != REQ_SKIP)
                  r.bits_value = field[23:0];
               if (rq.req_type != REQ_PEEK)
                  held_count -= n;
            end
         end
         REQ_RESTART: clear_reader();
         default: ;
      endcase
      r.marker_found   = marker_seen_r;
      r.marker_value   = marker_code;
      r.zeros_inserted = zero_fills;
      r.bits_available = 6'(held_count);
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers
   function automatic stim_row_type stim(logic [2:0] kind, logic [7:0] b, logic [4:0] cnt);
      stim_row_type row;
      row.req.req_type  = kind;
      row.req.data_byte = b;
      row.req.bit_count = cnt;
      row.fixed         = 1'b0;
      row.want          = '0;
      return row;
   endfunction

   function automatic stim_row_type stim_known(logic [2:0] kind, logic [7:0] b,
                                               logic [4:0] cnt, logic [23:0] v,
                                               logic [1:0] st, logic mf, logic [7:0] mv,
                                               logic [15:0] zc, logic [5:0] ba);
      stim_row_type row;
      row = stim(kind, b, cnt);
      row.fixed               = 1'b1;
      row.want.bits_value     = v;
      row.want.status         = st;
      row.want.marker_found   = mf;
      row.want.marker_value   = mv;
      row.want.zeros_inserted = zc;
      row.want.bits_available = ba;
      return row;
   endfunction

   function automatic logic [4:0] read_count();
      int p;
      p = $urandom_range(99);
      if (p < 10)
         return 5'd0;
      if (p < 60)
         return 5'($urandom_range(1, 8));
      if (p < 85)
         return 5'($urandom_range(9, 16));
      return 5'($urandom_range(17, 31));
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (mismatches < MAX_PRINTS)
         $display("%0t ns  %s: got 0x%0h, want 0x%0h", $time, what, got, want);
      mismatches++;
   endtask

   // Offer one request, idling first at random; returns at the accepting edge
   task automatic offer(stim_row_type row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      offered.push_back(row);
      req_valid <= 1'b1;
      req_data  <= row.req;
      do @(posedge clock); while (req_stall);
   endtask

   // Segments that open with a restart: pushes with mostly proper stuffing, reads,
   // a little noise, and about half of them closed by a marker and padded reads
   task automatic random_stretch(int quota);
      int         done;
      int         pick;
      logic [7:0] b;
      bit         marked;
      done = 0;
      while (done < quota) begin
         offer(stim(REQ_RESTART, 8'($urandom), 5'($urandom)));
         marked = 1'b0;
         done++;
         repeat ($urandom_range(8, 60)) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
               b = ($urandom_range(99) < 8) ? STUFF_BYTE : 8'($urandom);
               offer(stim(REQ_PUSH, b, 5'($urandom)));
               if (b == STUFF_BYTE && !marked) begin
                  b = ($urandom_range(99) < 85) ? 8'h00 : 8'($urandom);
                  offer(stim(REQ_PUSH, b, 5'($urandom)));
                  marked = (b != 8'h00);
               end
            end else if (pick < 95) begin
               offer(stim(3'($urandom_range(REQ_GET, REQ_SKIP)), 8'($urandom), read_count()));
            end else if (pick < 98) begin
               offer(stim(3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI)), 8'($urandom),
                          5'($urandom)));
            end else begin
               offer(stim(REQ_RESTART, 8'($urandom), 5'($urandom)));
               marked = 1'b0;
            end
            if (!marked)
               done++;
         end
         if (!marked && $urandom_range(1)) begin
            offer(stim(REQ_PUSH, STUFF_BYTE, 5'($urandom)));
            offer(stim(REQ_PUSH, 8'($urandom_range(1, 255)), 5'($urandom)));
            repeat ($urandom_range(2, 8)) begin
               offer(stim(3'($urandom_range(REQ_GET, REQ_SKIP)), 8'($urandom), read_count()));
               done++;
            end
            offer(stim(REQ_PUSH, 8'($urandom), 5'($urandom)));
            done += 2;
         end
      end
   endtask

   // ---------------------------------------------------------------- receiver stalls
   // random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_started != hold_requests) begin
         holds_started <= holds_started + 1;
         hold_left     <= HOLD_CYCLES;
         rsp_stall     <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // ---------------------------------------------------------------- prediction and checking
   always @(posedge clock) begin : response_check
      stim_row_type    row;
      rsp_payload_type want;
      if (!reset) begin
         // accepted request: predict, unless the table gives the answer outright
         if (req_valid && !req_stall) begin
            want = reader_response(req_data);
            if (offered.size() != 0) begin
               row = offered.pop_front();
               if (row.fixed)
                  want = row.want;
            end
            expected_rsp.push_back(want);
         end
         // delivered response
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("response with none expected", 32'(rsp_data.bits_value), 0);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.bits_value !== want.bits_value)
                  report_mismatch("bits_value", 32'(rsp_data.bits_value),
                                  32'(want.bits_value));
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
               if (rsp_data.marker_found !== want.marker_found)
                  report_mismatch("marker_found", 32'(rsp_data.marker_found),
                                  32'(want.marker_found));
               if (rsp_data.marker_value !== want.marker_value)
                  report_mismatch("marker_value", 32'(rsp_data.marker_value),
                                  32'(want.marker_value));
               if (rsp_data.zeros_inserted !== want.zeros_inserted)
                  report_mismatch("zeros_inserted", 32'(rsp_data.zeros_inserted),
                                  32'(want.zeros_inserted));
               if (rsp_data.bits_available !== want.bits_available)
                  report_mismatch("bits_available", 32'(rsp_data.bits_available),
                                  32'(want.bits_available));
            end
         end
      end
   end

   // ---------------------------------------------------------------- main sequence
   initial begin
      stim_row_type directed_rows[$];
      int           waited;

      clear_reader();

      // directed table: short reads, counts of zero and above 24, lone 0xFF,
      // full reservoir with a refused pair, marker, ignored push, padding, no-ops
      directed_rows.push_back(stim_known(REQ_GET, 8'h00, 5'd8,
                                         24'h0, ST_SHORT, 1'b0, 8'h00, 16'd0, 6'd0));
      directed_rows.push_back(stim_known(REQ_PUSH, 8'h00, 5'd0,
                                         24'h0, ST_OK, 1'b0, 8'h00, 16'd0, 6'd8));
      directed_rows.push_back(stim_known(REQ_PUSH, 8'hA5, 5'd31,
                                         24'h0, ST_OK, 1'b0, 8'h00, 16'd0, 6'd16));
      directed_rows.push_back(stim_known(REQ_PEEK, 8'hFF, 5'd0,
                                         24'h0, ST_OK, 1'b0, 8'h00, 16'd0, 6'd16));
      directed_rows.push_back(stim_known(REQ_PEEK, 8'h00, 5'd31,
                                         24'h0, ST_SHORT, 1'b0, 8'h00, 16'd0, 6'd16));
      directed_rows.push_back(stim_known(REQ_PUSH, STUFF_BYTE, 5'd0,
                                         24'h0, ST_OK, 1'b0, 8'h00, 16'd0, 6'd16));
      directed_rows.push_back(stim_known(REQ_GET, 8'h00, MAX_REQ_BITS,
                                         24'h0, ST_SHORT, 1'b0, 8'h00, 16'd0, 6'd16));
      directed_rows.push_back(stim_known(REQ_PUSH, 8'h00, 5'd0,
                                         24'h0, ST_OK, 1'b0, 8'h00, 16'd0, 6'd24));
      directed_rows.push_back(stim_known(REQ_PEEK, 8'h00, MAX_REQ_BITS,
                                         24'h00A5FF, ST_OK, 1'b0, 8'h00, 16'd0, 6'd24));
      directed_rows.push_back(stim_known(REQ_PUSH, 8'h3C, 5'd0,
                                         24'h0, ST_OK, 1'b0, 8'h00, 16'd0, 6'd32));
      directed_rows.push_back(stim_known(REQ_PUSH, 8'h01, 5'd0,
                                         24'h0, ST_FULL, 1'b0, 8'h00, 16'd0, 6'd32));
      directed_rows.push_back(stim_known(REQ_PUSH, STUFF_BYTE, 5'd0,
                                         24'h0, ST_OK, 1'b0, 8'h00, 16'd0, 6'd32));
      directed_rows.push_back(stim_known(REQ_PUSH, 8'h00, 5'd0,
                                         24'h0, ST_FULL, 1'b0, 8'h00, 16'd0, 6'd32));
      directed_rows.push_back(stim_known(REQ_SKIP, 8'h00, 5'd8,
                                         24'h0, ST_OK, 1'b0, 8'h00, 16'd0, 6'd24));
      // refused pair completes on the repeated 0x00
      directed_rows.push_back(stim_known(REQ_PUSH, 8'h00, 5'd0,
                                         24'h0, ST_OK, 1'b0, 8'h00, 16'd0, 6'd32));
      directed_rows.push_back(stim_known(REQ_GET, 8'h00, MAX_REQ_BITS,
                                         24'hA5FF3C, ST_OK, 1'b0, 8'h00, 16'd0, 6'd8));
      directed_rows.push_back(stim(REQ_GET, 8'h00, 5'd1));
      directed_rows.push_back(stim(REQ_PUSH, STUFF_BYTE, 5'd0));
      directed_rows.push_back(stim(REQ_PUSH, 8'hD0, 5'd0));
      directed_rows.push_back(stim_known(REQ_PUSH, 8'h12, 5'd0,
                                         24'h0, ST_IGNORED, 1'b1, 8'hD0, 16'd0, 6'd7));
      directed_rows.push_back(stim(REQ_GET, 8'h00, MAX_REQ_BITS));
      directed_rows.push_back(stim(REQ_UNUSED_LO, STUFF_BYTE, 5'd31));
      directed_rows.push_back(stim(REQ_UNUSED_HI, 8'h00, 5'd0));
      directed_rows.push_back(stim_known(REQ_RESTART, STUFF_BYTE, 5'd31,
                                         24'h0, ST_OK, 1'b0, 8'h00, 16'd0, 6'd0));
      directed_rows.push_back(stim_known(REQ_GET, 8'h00, 5'd0,
                                         24'h0, ST_OK, 1'b0, 8'h00, 16'd0, 6'd0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         offer(directed_rows[i]);

      // random segments under each idling pattern
      random_stretch(375);
      send_idle_pct = 62;
      random_stretch(375);
      send_idle_pct = 0;
      stall_pct     = 62;
      random_stretch(375);
      send_idle_pct = 21;
      stall_pct     = 21;
      random_stretch(375);

      // long receiver hold-off while requests keep coming, to fill the block
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_requests++;
      random_stretch(60);

      // drain
      req_valid <= 1'b0;
      @(posedge clock);
      for (waited = 0; waited < 2000 && expected_rsp.size() != 0; waited++)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (expected_rsp.size() != 0)
         report_mismatch("responses never delivered", expected_rsp.size(), 0);

      if (mismatches == 0)
         $display("jpeg_entropy_bit_reader: match");
      else
         $display("jpeg_entropy_bit_reader: mismatch");
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("jpeg_entropy_bit_reader: mismatch");
      $finish;
   end

endmodule
